FILE: rtl/oac_pkg.sv
// ----------------------------------------------------------------------------
// Orbital anomaly converter package
// Shared types, fixed-point constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package oac_pkg;

  // Fixed-point formats
  localparam int ANGLE_FRAC_BITS = 28;
  localparam int UNIT_BITS       = 30;
  localparam int ECC_BITS        = 24;
  localparam int ECC_SHIFT       = ECC_BITS + UNIT_BITS - ANGLE_FRAC_BITS;
  localparam int HALF_E_SHIFT    = ANGLE_FRAC_BITS - ECC_BITS - 1;
  localparam int CORDIC_STEPS    = 30;

  // Angles in Q3.60 for the CORDIC, and the full turn in the Q3.28 output format
  localparam logic signed [63:0] TWO_PI_Q60  = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] HALF_PI_Q60 = 64'sh1921FB54442D1846;
  localparam logic [30:0]        TWO_PI_A    = 31'h6487ED51;

  // Configuration register indexes
  localparam logic REG_MAX_STEPS = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  // Conversion codes
  typedef enum logic [2:0] {
    OP_TRUE2ECC  = 3'd0,
    OP_TRUE2MEAN = 3'd1,
    OP_MEAN2ECC  = 3'd2,
    OP_MEAN2TRUE = 3'd3,
    OP_ECC2TRUE  = 3'd4,
    OP_ECC2MEAN  = 3'd5
  } opcode_t;

  // Command to the CORDIC unit
  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_ctl_t;

  typedef logic [CORDIC_STEPS-1:0][63:0] atan_tab_t;

  // Round-half-up arithmetic right shift, for positive shift counts
  function automatic logic signed [63:0] shr_round_c(input logic signed [63:0] v,
                                                     input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Restoring unsigned division, used only while building the constants
  function automatic logic [63:0] udiv_c(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Bitwise integer square root of a 64-bit value
  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitm;
    rem  = v;
    res  = 64'd0;
    bitm = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitm) begin
        rem = rem - (res + bitm);
        res = (res >> 1) + bitm;
      end else begin
        res = res >> 1;
      end
      bitm = bitm >> 2;
    end
    return res;
  endfunction

  // atan(2^-i) in Q3.60, from the arctangent series evaluated in Q62
  function automatic atan_tab_t build_atan();
    atan_tab_t tab;
    longint sum;
    longint term;
    int ex;
    tab[0] = shr_round_c(PI_Q60, 2);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      sum = 0;
      for (int k = 0; k < 32; k++) begin
        ex = 62 - i * (2 * k + 1);
        if (ex >= 0) begin
          term = longint'(udiv_c(64'd1 << ex, 64'(2 * k + 1)));
          if ((k & 1) != 0) sum = sum - term;
          else sum = sum + term;
        end
      end
      tab[i] = shr_round_c(sum, 2);
    end
    return tab;
  endfunction

  // Reciprocal of the CORDIC gain in Q1.30
  function automatic logic [63:0] build_gain_inv();
    logic [63:0] g;
    g = 64'd1 << 60;
    for (int i = 0; i < CORDIC_STEPS; i++) g = g + (g >> (2 * i));
    return udiv_c(64'd1 << 60, isqrt_c(g));
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();
  localparam logic signed [35:0] GAIN_INV = 36'(build_gain_inv());

endpackage

FILE: rtl/oac_cordic.sv
// ----------------------------------------------------------------------------
// Orbital anomaly converter CORDIC unit
// Iterative CORDIC, one micro-rotation per cycle, in rotation mode (sine and
// cosine of a Q3.60 angle) or vectoring mode (angle of an x/y pair).
// ----------------------------------------------------------------------------
module oac_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  oac_pkg::cordic_ctl_t ctl,
  input  logic signed [35:0]   x_init,
  input  logic signed [35:0]   y_init,
  input  logic signed [63:0]   z_init,
  output logic                 done,
  output logic signed [35:0]   x_out,
  output logic signed [35:0]   y_out,
  output logic signed [63:0]   z_out
);
  import oac_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FOLD_TURN, S_FOLD_PI, S_FOLD_HALF, S_PRE_VEC, S_ITER, S_DONE
  } state_t;

  state_t             state;
  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [63:0] z;
  logic               vec_mode;
  logic               flip;
  logic [4:0]         step;
  logic signed [35:0] dx;
  logic signed [35:0] dy;
  logic               sigma;

  // Shifted terms and rotation direction for this step
  always_comb begin
    dx    = y >>> step;
    dy    = x >>> step;
    sigma = vec_mode ? y[35] : !z[63];
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            vec_mode <= ctl.vec_mode;
            flip     <= 1'b0;
            step     <= '0;
            if (ctl.vec_mode) begin
              x     <= x_init;
              y     <= y_init;
              z     <= '0;
              state <= S_PRE_VEC;
            end else begin
              x     <= GAIN_INV;
              y     <= '0;
              z     <= z_init;
              state <= S_FOLD_TURN;
            end
          end
        end
        // Bring the angle into one turn, then into [-pi, pi]
        S_FOLD_TURN: begin
          if (z >= TWO_PI_Q60) z <= z - TWO_PI_Q60;
          state <= S_FOLD_PI;
        end
        S_FOLD_PI: begin
          if (z > PI_Q60) z <= z - TWO_PI_Q60;
          else if (z < -PI_Q60) z <= z + TWO_PI_Q60;
          state <= S_FOLD_HALF;
        end
        // Fold into [-pi/2, pi/2]; the result is negated at the end
        S_FOLD_HALF: begin
          if (z > HALF_PI_Q60) begin
            z    <= z - PI_Q60;
            flip <= 1'b1;
          end else if (z < -HALF_PI_Q60) begin
            z    <= z + PI_Q60;
            flip <= 1'b1;
          end
          state <= S_ITER;
        end
        // Vectors in the left half plane start from +/- pi
        S_PRE_VEC: begin
          if (x[35]) begin
            z <= y[35] ? -PI_Q60 : PI_Q60;
            x <= -x;
            y <= -y;
          end
          state <= S_ITER;
        end
        S_ITER: begin
          if (sigma) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - $signed(ATAN_TAB[step]);
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + $signed(ATAN_TAB[step]);
          end
          if (step == 5'(CORDIC_STEPS - 1)) state <= S_DONE;
          else step <= step + 5'd1;
        end
        S_DONE: begin
          if (flip) begin
            x <= -x;
            y <= -y;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = z;

endmodule

FILE: rtl/oac_isqrt.sv
// ----------------------------------------------------------------------------
// Orbital anomaly converter square root unit
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module oac_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import oac_pkg::*;

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitm;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitm;

  // One trial subtraction per cycle, from the top bit pair down
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        res  <= '0;
        bitm <= 64'd1 << 62;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[31:0];

endmodule

FILE: rtl/oac_divider.sv
// ----------------------------------------------------------------------------
// Orbital anomaly converter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module oac_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [62:0] quotient
);
  import oac_pkg::*;

  logic [62:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem, quo[62]};
  assign fits    = shifted >= {1'b0, dvs};

  // Dividend bits shift out of the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
        count <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= fits ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
        quo   <= {quo[61:0], fits};
        count <= count + 6'd1;
        if (count == 6'd62) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/orbital_anomaly_converter_unit.sv
// ----------------------------------------------------------------------------
// Orbital anomaly converter
// Converts between true, eccentric and mean anomaly; solves Kepler's equation
// by Newton steps on a shared CORDIC, divider and multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transfer carries the opcode (s_tuser), the signed
//   Q3.28 angle and the Q0.24 eccentricity (s_tdata). s_tready is high only
//   while the sequencer is idle; one item is worked on at a time.
//   Output channel m_*: one transfer per item with the angle in [0, 2*pi)
//   (m_tdata) and the not-converged flag (m_tuser). The result sits in an
//   output register, so the next item is taken while it waits for m_tready.
//   Configuration: cfg_we writes max_newton_steps (index 0) or
//   newton_tolerance (index 1) from cfg_data; write only while idle.
// Sequence: wrapping adds or removes one turn per step. A true/eccentric
//   conversion runs two square roots, a CORDIC rotation and a CORDIC
//   vectoring pass; eccentric-to-mean runs one CORDIC pass. Each Newton step
//   runs one CORDIC pass, two products and the bit-serial divider, so a
//   Kepler solve grows with the number of steps.
// Reset: rst clears the sequencer and the output valid and loads the register
//   reset values (1000 steps, tolerance 3). A stalled receiver holds the
//   result; the finished next item then waits until the output register frees.
// ----------------------------------------------------------------------------
module orbital_anomaly_converter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // angle_in [31:0], eccentricity [55:32]
  input  logic [2:0]  s_tuser,   // opcode [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // angle_out [30:0], zero pad [31]
  output logic        m_tuser,   // not_converged [0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  import oac_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WRAP, ST_DISPATCH,
    ST_H_START, ST_H_SQP, ST_H_SQM, ST_H_ROT, ST_H_SC, ST_H_MY, ST_H_MX,
    ST_H_VEC, ST_H_VW,
    ST_E_START, ST_E_SC, ST_E_MUL, ST_E_FIN,
    ST_K_INIT, ST_K_CHECK, ST_K_ROT, ST_K_SC, ST_K_MS, ST_K_MC, ST_K_DF, ST_K_DIV,
    ST_FINISH
  } state_t;

  state_t             state;
  state_t             wrap_ret;
  opcode_t            opcode;
  logic [23:0]        ecc;
  logic signed [33:0] wv;
  logic [30:0]        res;
  logic [31:0]        sp;
  logic [31:0]        sm;
  logic signed [32:0] c_val;
  logic signed [32:0] s_val;
  logic signed [32:0] vy;
  logic signed [33:0] ea;
  logic signed [33:0] f_val;
  logic [62:0]        mag;
  logic [9:0]         n_steps;
  logic               fail;
  logic [9:0]         max_steps;
  logic [7:0]         tol;
  logic [30:0]        out_angle;
  logic               out_fail;
  logic               out_valid;
  logic signed [65:0] prod;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic               to_true;
  logic signed [65:0] rnd_unit;
  logic signed [65:0] rnd_ecc;
  logic signed [65:0] rnd_cos;
  logic signed [33:0] t_ext;
  logic [24:0]        ecc_plus;
  logic [24:0]        ecc_minus;
  logic signed [32:0] df_raw;
  logic [31:0]        df;
  logic [32:0]        fa;
  logic [62:0]        q_clamp;
  logic signed [63:0] r_step;
  logic signed [63:0] ea_step;
  logic signed [33:0] ea_new;
  logic signed [63:0] hz;
  logic               keep_going;

  cordic_ctl_t        cordic_ctl;
  logic signed [35:0] cordic_x0;
  logic signed [35:0] cordic_y0;
  logic signed [63:0] cordic_z0;
  logic               cordic_done;
  logic signed [35:0] cordic_x;
  logic signed [35:0] cordic_y;
  logic signed [63:0] cordic_z;
  logic               sq_start;
  logic [63:0]        sq_in;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic               div_start;
  logic               div_done;
  logic [62:0]        div_quot;

  function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                     input int n);
    return (v + (66'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Shared units
  oac_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .ctl    (cordic_ctl),
    .x_init (cordic_x0),
    .y_init (cordic_y0),
    .z_init (cordic_z0),
    .done   (cordic_done),
    .x_out  (cordic_x),
    .y_out  (cordic_y),
    .z_out  (cordic_z)
  );

  oac_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  oac_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({fa, 30'b0}),
    .divisor  (df),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Datapath arithmetic around the shared units
  always_comb begin
    to_true   = (opcode == OP_MEAN2TRUE) || (opcode == OP_ECC2TRUE);
    t_ext     = $signed({3'b0, TWO_PI_A});
    ecc_plus  = {1'b1, 24'b0} + {1'b0, ecc};
    ecc_minus = {1'b1, 24'b0} - {1'b0, ecc};

    // Multiplier operands follow the state
    ma = $signed({9'b0, ecc});
    mb = s_val;
    unique case (state)
      ST_H_MY: begin
        ma = $signed({1'b0, to_true ? sp : sm});
        mb = s_val;
      end
      ST_H_MX: begin
        ma = $signed({1'b0, to_true ? sm : sp});
        mb = c_val;
      end
      ST_K_MC: mb = c_val;
      default: ;
    endcase

    rnd_unit = round_shift(prod, UNIT_BITS);
    rnd_ecc  = round_shift(prod, ECC_SHIFT);
    rnd_cos  = round_shift(prod, ECC_BITS);

    // Newton denominator with its floor of one LSB
    df_raw = 33'sd1073741824 - $signed(rnd_cos[32:0]);
    df     = (df_raw < 33'sd1) ? 32'd1 : df_raw[31:0];
    fa     = f_val[33] ? 33'(-f_val) : f_val[32:0];

    // Newton update, step limited to 2^62 and result held in [0, 2*pi]
    q_clamp = (div_quot > (63'd1 << 62)) ? (63'd1 << 62) : div_quot;
    r_step  = f_val[33] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
    ea_step = 64'(ea) - r_step;
    if (ea_step < 64'sd0) ea_new = '0;
    else if (ea_step > 64'(t_ext)) ea_new = t_ext;
    else ea_new = 34'(ea_step);

    // Twice the vectoring angle, back to Q3.28 with rounding
    hz = {cordic_z[62:0], 1'b0} + 64'sd2147483648;

    keep_going = (mag > {55'b0, tol}) && (n_steps < max_steps);

    // Unit commands
    sq_start  = (state == ST_H_START) || ((state == ST_H_SQP) && sq_done);
    sq_in     = (state == ST_H_START) ? {3'b0, ecc_plus, 36'b0} : {3'b0, ecc_minus, 36'b0};
    div_start = (state == ST_K_DF);

    cordic_ctl.start    = (state == ST_H_ROT) || (state == ST_H_VEC) ||
                          (state == ST_E_START) || (state == ST_K_ROT);
    cordic_ctl.vec_mode = (state == ST_H_VEC);
    cordic_x0 = 36'(rnd_unit);
    cordic_y0 = 36'(vy);
    unique case (state)
      ST_H_ROT:   cordic_z0 = {2'b0, res, 31'b0};
      ST_E_START: cordic_z0 = {1'b0, res, 32'b0};
      default:    cordic_z0 = {1'b0, ea[30:0], 32'b0};
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps <= 10'd1000;
      tol       <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_STEPS: max_steps <= cfg_data;
        REG_TOLERANCE: tol       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output register empties on a transfer unless a new result loads it
      if (m_tvalid && m_tready && (state != ST_FINISH)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            opcode   <= opcode_t'(s_tuser);
            ecc      <= s_tdata[55:32];
            wv       <= {{2{s_tdata[31]}}, s_tdata[31:0]};
            fail     <= 1'b0;
            wrap_ret <= ST_DISPATCH;
            state    <= ST_WRAP;
          end
        end
        // Add or remove whole turns until the angle lies in [0, 2*pi)
        ST_WRAP: begin
          if (wv < 34'sd0) wv <= wv + t_ext;
          else if (wv >= t_ext) wv <= wv - t_ext;
          else begin
            res   <= wv[30:0];
            state <= wrap_ret;
          end
        end
        ST_DISPATCH: begin
          unique case (opcode)
            OP_TRUE2ECC, OP_TRUE2MEAN, OP_ECC2TRUE: state <= ST_H_START;
            OP_MEAN2ECC, OP_MEAN2TRUE:              state <= ST_K_INIT;
            OP_ECC2MEAN:                            state <= ST_E_START;
            default:                                state <= ST_FINISH;
          endcase
        end
        // Half-angle map: square roots of 1+e and 1-e, then sin/cos, then atan2
        ST_H_START: state <= ST_H_SQP;
        ST_H_SQP: begin
          if (sq_done) begin
            sp    <= sq_root;
            state <= ST_H_SQM;
          end
        end
        ST_H_SQM: begin
          if (sq_done) begin
            sm    <= sq_root;
            state <= ST_H_ROT;
          end
        end
        ST_H_ROT: state <= ST_H_SC;
        ST_H_SC: begin
          if (cordic_done) begin
            c_val <= cordic_x[32:0];
            s_val <= cordic_y[32:0];
            state <= ST_H_MY;
          end
        end
        ST_H_MY: state <= ST_H_MX;
        ST_H_MX: begin
          vy    <= rnd_unit[32:0];
          state <= ST_H_VEC;
        end
        ST_H_VEC: state <= ST_H_VW;
        ST_H_VW: begin
          if (cordic_done) begin
            wv       <= {{2{hz[63]}}, hz[63:32]};
            wrap_ret <= (opcode == OP_TRUE2MEAN) ? ST_E_START : ST_FINISH;
            state    <= ST_WRAP;
          end
        end
        // Eccentric to mean: M = E - e*sin(E)
        ST_E_START: state <= ST_E_SC;
        ST_E_SC: begin
          if (cordic_done) begin
            s_val <= cordic_y[32:0];
            state <= ST_E_MUL;
          end
        end
        ST_E_MUL: state <= ST_E_FIN;
        ST_E_FIN: begin
          wv       <= $signed({3'b0, res}) - $signed(rnd_ecc[33:0]);
          wrap_ret <= ST_FINISH;
          state    <= ST_WRAP;
        end
        // Kepler solve, starting at M - e/2 past pi and M + e/2 at or below it
        ST_K_INIT: begin
          if ($signed({1'b0, res, 32'b0}) > PI_Q60)
            ea <= $signed({3'b0, res}) - $signed(34'(ecc) << HALF_E_SHIFT);
          else
            ea <= $signed({3'b0, res}) + $signed(34'(ecc) << HALF_E_SHIFT);
          n_steps <= '0;
          mag     <= 63'd1 << ANGLE_FRAC_BITS;
          state   <= ST_K_CHECK;
        end
        ST_K_CHECK: begin
          if (keep_going) begin
            n_steps <= n_steps + 10'd1;
            state   <= ST_K_ROT;
          end else begin
            fail     <= mag > {55'b0, tol};
            wv       <= ea;
            wrap_ret <= (opcode == OP_MEAN2TRUE) ? ST_H_START : ST_FINISH;
            state    <= ST_WRAP;
          end
        end
        ST_K_ROT: state <= ST_K_SC;
        ST_K_SC: begin
          if (cordic_done) begin
            c_val <= cordic_x[32:0];
            s_val <= cordic_y[32:0];
            state <= ST_K_MS;
          end
        end
        ST_K_MS: state <= ST_K_MC;
        ST_K_MC: begin
          f_val <= ea - $signed(rnd_ecc[33:0]) - $signed({3'b0, res});
          state <= ST_K_DF;
        end
        ST_K_DF: state <= ST_K_DIV;
        ST_K_DIV: begin
          if (div_done) begin
            mag   <= q_clamp;
            ea    <= ea_new;
            state <= ST_K_CHECK;
          end
        end
        // Load the output register once it is free
        ST_FINISH: begin
          if (!out_valid || m_tready) begin
            out_angle <= res;
            out_fail  <= fail;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_angle};
  assign m_tuser  = out_fail;

  // Results always lie inside one turn
  assert property (@(posedge clk) disable iff (rst) out_valid |-> out_angle < TWO_PI_A)
    else $error("result angle outside [0, 2*pi)");

  // The Newton loop never runs past its step limit
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_K_CHECK) |-> n_steps <= max_steps)
    else $error("Newton step count above limit");

  // CORDIC results arrive only while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
                   cordic_done |-> (state == ST_H_SC || state == ST_H_VW ||
                                    state == ST_E_SC || state == ST_K_SC))
    else $error("CORDIC result with no consumer");

endmodule
